FILE: hdl/wind_course_correction_unit_defines.svh
// Assertion macros shared by the course correction block.
`ifndef WIND_COURSE_CORRECTION_UNIT_DEFINES_SVH
`define WIND_COURSE_CORRECTION_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define WCC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked at the next clock edge.
`define WCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/wcc_pkg.sv
// ----------------------------------------------------------------------------
// wcc_pkg
// Types and case codes shared by the course correction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package wcc_pkg;
    typedef enum logic [2:0] {
        CASE_HOVER    = 3'd0,
        CASE_NO_ROOT  = 3'd1,
        CASE_TANGENT  = 3'd2,
        CASE_BACKWARD = 3'd3,
        CASE_FORWARD  = 3'd4
    } case_t;

    // Width of the internal wide arithmetic.
    localparam int WIDE = 64;
endpackage
`default_nettype wire

FILE: hdl/wcc_isqrt.sv
// ----------------------------------------------------------------------------
// wcc_isqrt
// Pipelined integer square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wcc_isqrt #(
    parameter int IN_W = 64,
    parameter int TAG_W = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic [IN_W-1:0]    radicand,
    input  wire logic [TAG_W-1:0]   tag_in,
    output logic [IN_W/2-1:0]       root,
    output logic [TAG_W-1:0]        tag_out
);
    localparam int N = IN_W / 2;

    logic [IN_W-1:0]  rem_reg [0:N];
    logic [N-1:0]     q_reg   [0:N];
    logic [IN_W-1:0]  rad_reg [0:N];
    logic [TAG_W-1:0] tag_reg [0:N];

    always_comb begin
        rad_reg[0] = radicand;
        rem_reg[0] = '0;
        q_reg[0]   = '0;
        tag_reg[0] = tag_in;
    end

    // Each stage brings down two radicand bits and tries one root bit.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [IN_W+1:0] trial;
        logic [IN_W+1:0] rem_sh;
        always_comb begin
            rem_sh = {rem_reg[i], rad_reg[i][IN_W-1 -: 2]};
            trial  = {{(IN_W+2-N-2){1'b0}}, q_reg[i], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i+1] <= rad_reg[i] << 2;
                tag_reg[i+1] <= tag_reg[i];
                if (rem_sh >= trial) begin
                    rem_reg[i+1] <= IN_W'(rem_sh - trial);
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= IN_W'(rem_sh);
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign root    = q_reg[N];
    assign tag_out = tag_reg[N];

    logic unused_rst;
    assign unused_rst = aresetn;
endmodule
`default_nettype wire

FILE: hdl/wcc_divider.sv
// ----------------------------------------------------------------------------
// wcc_divider
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wcc_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int TAG_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic [NUM_W-1:0]      quot,
    output logic [TAG_W-1:0]      tag_out
);
    logic [DEN_W:0]   rem_reg [0:NUM_W];
    logic [NUM_W-1:0] num_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic [TAG_W-1:0] tag_reg [0:NUM_W];

    always_comb begin
        rem_reg[0] = '0;
        num_reg[0] = numer;
        den_reg[0] = denom;
        tag_reg[0] = tag_in;
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W+1:0] sh;
        always_comb sh = {rem_reg[i], num_reg[i][NUM_W-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
                if (sh >= {2'b00, den_reg[i]}) begin
                    rem_reg[i+1] <= (DEN_W+1)'(sh - {2'b00, den_reg[i]});
                    num_reg[i+1] <= {num_reg[i][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= (DEN_W+1)'(sh);
                    num_reg[i+1] <= {num_reg[i][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quot    = num_reg[NUM_W];
    assign tag_out = tag_reg[NUM_W];
endmodule
`default_nettype wire

FILE: hdl/wind_course_correction_unit.sv
// ----------------------------------------------------------------------------
// wind_course_correction_unit
// Wind triangle solver: course vector that keeps ground track on the desired
// direction for a given airspeed.
// ----------------------------------------------------------------------------
// A new beat may be taken in every cycle and one result beat comes out per
// input beat, in order. The pipeline has an input register, then the two
// length roots side by side with DATA_WIDTH+1 stages, then the unit-vector
// dividers with DATA_WIDTH+FRACTION_BITS stages, then three product stages.
// The root of the speed margin follows with 2*DATA_WIDTH+4 stages, then two
// more product stages, the result register and the first skid entry. That
// makes 4*DATA_WIDTH+FRACTION_BITS+13 register stages. The whole pipeline
// advances only when the two-entry skid buffer on the output has room, so a
// stall on the result side holds every stage. s_ready comes straight from
// the registered skid count. It drops only while both skid entries are full,
// and it returns in the cycle after a result beat leaves.
`default_nettype none
`include "wind_course_correction_unit_defines.svh"
module wind_course_correction_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_WIDTH-1:0] s_desired_north,
    input  wire logic [DATA_WIDTH-1:0] s_desired_east,
    input  wire logic [DATA_WIDTH-1:0] s_wind_north,
    input  wire logic [DATA_WIDTH-1:0] s_wind_east,
    input  wire logic [DATA_WIDTH-1:0] s_air_speed,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_WIDTH-1:0]      m_course_north,
    output logic [DATA_WIDTH-1:0]      m_course_east,
    output logic                       m_solution_valid,
    output logic [2:0]                 m_solution_case
);
    import wcc_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int W  = 2 * DW + 4;               // wide signed working width
    localparam int SQ_W = 2 * DW + 2;             // radicand width (even)
    localparam int NUM_W = DW + FB;               // divider numerator width
    localparam int MA_W = DW + 4;                 // course-sized product operand
    localparam int MB_W = FB + 2;                 // unit-vector product operand
    localparam logic signed [W-1:0] TOL = W'(((64'd1 << FB) + 64'd500) / 64'd1000);

    // Signed values are carried in one wide vector per item so the
    // long arithmetic units can pass them as a tag.
    typedef struct packed {
        logic signed [DW-1:0] dn;
        logic signed [DW-1:0] de;
        logic signed [DW-1:0] wn;
        logic signed [DW-1:0] we;
        logic [DW-1:0]        s;
        logic                 vld;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // Global advance: the pipeline moves when the skid buffer has room.
    logic       adv;
    logic [1:0] cnt_reg;
    assign adv     = (cnt_reg < 2'd2);
    assign s_ready = adv;

    // Stage 0: capture and magnitudes.
    item_t in_it;
    always_comb begin
        in_it.dn  = s_desired_north;
        in_it.de  = s_desired_east;
        in_it.wn  = s_wind_north;
        in_it.we  = s_wind_east;
        in_it.s   = s_air_speed[DW-1] ? DW'(-s_air_speed) : s_air_speed;
        in_it.vld = s_valid;
    end

    function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] x);
        magn = x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    item_t s1_reg;
    logic [SQ_W-1:0] rv_reg, rf_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_reg.vld <= in_it.vld;
        end
        if (adv) begin
            s1_reg.dn <= in_it.dn; s1_reg.de <= in_it.de;
            s1_reg.wn <= in_it.wn; s1_reg.we <= in_it.we; s1_reg.s <= in_it.s;
            rv_reg <= SQ_W'({{DW{1'b0}}, magn(in_it.dn)} * {{DW{1'b0}}, magn(in_it.dn)})
                    + SQ_W'({{DW{1'b0}}, magn(in_it.de)} * {{DW{1'b0}}, magn(in_it.de)});
            rf_reg <= SQ_W'({{DW{1'b0}}, magn(in_it.wn)} * {{DW{1'b0}}, magn(in_it.wn)})
                    + SQ_W'({{DW{1'b0}}, magn(in_it.we)} * {{DW{1'b0}}, magn(in_it.we)});
        end
    end

    // Square roots of both lengths run side by side; the item rides in the tag.
    logic [SQ_W/2-1:0] v_root, f_root;
    logic [ITEM_W-1:0] it_a;
    logic [ITEM_W-1:0] dummy_tag;
    wcc_isqrt #(.IN_W(SQ_W), .TAG_W(ITEM_W)) u_sqrt_v (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .radicand(rv_reg),
        .tag_in(s1_reg), .root(v_root), .tag_out(it_a)
    );
    wcc_isqrt #(.IN_W(SQ_W), .TAG_W(ITEM_W)) u_sqrt_f (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .radicand(rf_reg),
        .tag_in(s1_reg), .root(f_root), .tag_out(dummy_tag)
    );
    item_t it_a_s;
    assign it_a_s = item_t'(it_a);

    // Valid bit travels outside the isqrt tag path too, with reset.
    localparam int SQ_LAT = SQ_W / 2;
    logic [SQ_LAT-1:0] vq_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vq_reg <= '0;
        else if (adv) vq_reg <= {vq_reg[SQ_LAT-2:0], s1_reg.vld};
    end

    // Divider: both unit components, v and f carried along.
    localparam int TAG2_W = ITEM_W + 2 * (SQ_W / 2);
    logic [NUM_W-1:0] qn, qe;
    logic [TAG2_W-1:0] t2_in, t2_out, t2_dummy;
    logic [NUM_W-1:0] num_n, num_e;
    logic [DW-1:0] den_v;
    assign t2_in = {it_a, v_root, f_root};
    assign num_n = {magn(it_a_s.dn), {FB{1'b0}}};
    assign num_e = {magn(it_a_s.de), {FB{1'b0}}};
    // A zero length yields an all-ones quotient; that item takes the hover
    // case and never uses it.
    assign den_v = DW'(v_root);
    wcc_divider #(.NUM_W(NUM_W), .DEN_W(DW), .TAG_W(TAG2_W)) u_div_n (
        .aclk(aclk), .en(adv), .numer(num_n), .denom(den_v),
        .tag_in(t2_in), .quot(qn), .tag_out(t2_out)
    );
    wcc_divider #(.NUM_W(NUM_W), .DEN_W(DW), .TAG_W(TAG2_W)) u_div_e (
        .aclk(aclk), .en(adv), .numer(num_e), .denom(den_v),
        .tag_in(t2_in), .quot(qe), .tag_out(t2_dummy)
    );
    logic [NUM_W-1:0] vd_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= '0;
        else if (adv) vd_reg <= {vd_reg[NUM_W-2:0], vq_reg[SQ_LAT-1]};
    end

    item_t it_b;
    logic [SQ_W/2-1:0] v_b, f_b;
    assign {it_b, v_b, f_b} = t2_out;

    // Floor of a*b / 2^FB. The first operand is a course-sized value and the
    // second a unit-vector component, so both fit far narrower words.
    function automatic logic signed [W-1:0] mq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        logic signed [MA_W-1:0] a_t;
        logic signed [MB_W-1:0] b_t;
        logic signed [MA_W+MB_W-1:0] p;
        a_t = a[MA_W-1:0];
        b_t = b[MB_W-1:0];
        p   = (MA_W+MB_W)'(a_t) * (MA_W+MB_W)'(b_t);
        mq  = W'(p >>> FB);
    endfunction

    // Floor of x^2 / 2^FB for a cross-track component or the airspeed.
    function automatic logic signed [W-1:0] sqq(input logic signed [W-1:0] x);
        logic [DW+1:0] m;
        logic [W-1:0]  p;
        m   = x[W-1] ? (DW+2)'(-x) : x[DW+1:0];
        p   = {{(DW+2){1'b0}}, m} * {{(DW+2){1'b0}}, m};
        sqq = W'(p >> FB);
    endfunction

    // Stage B1: unit vector and along-track wind products.
    logic signed [W-1:0] un_reg, ue_reg, wn_b1, we_b1, p1_reg, p2_reg;
    item_t b1_reg; logic [SQ_W/2-1:0] v_b1, f_b1; logic vb1_reg;
    logic signed [W-1:0] un_c, ue_c;
    assign un_c = it_b.dn[DW-1] ? -W'(qn) : W'(qn);
    assign ue_c = it_b.de[DW-1] ? -W'(qe) : W'(qe);
    always_ff @(posedge aclk) begin
        if (!aresetn) vb1_reg <= 1'b0;
        else if (adv) vb1_reg <= vd_reg[NUM_W-1];
        if (adv) begin
            b1_reg <= it_b; v_b1 <= v_b; f_b1 <= f_b;
            un_reg <= un_c; ue_reg <= ue_c;
            p1_reg <= mq(W'(it_b.wn), un_c);
            p2_reg <= mq(W'(it_b.we), ue_c);
        end
    end
    assign wn_b1 = W'(b1_reg.wn);
    assign we_b1 = W'(b1_reg.we);

    // Stage B2: cross-track wind component.
    logic signed [W-1:0] fon_reg, foe_reg, un2, ue2;
    item_t b2_reg; logic [SQ_W/2-1:0] v_b2, f_b2; logic vb2_reg;
    logic signed [W-1:0] fp_c;
    assign fp_c = p1_reg + p2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vb2_reg <= 1'b0;
        else if (adv) vb2_reg <= vb1_reg;
        if (adv) begin
            b2_reg <= b1_reg; v_b2 <= v_b1; f_b2 <= f_b1;
            un2 <= un_reg; ue2 <= ue_reg;
            fon_reg <= wn_b1 - mq(fp_c, un_reg);
            foe_reg <= we_b1 - mq(fp_c, ue_reg);
        end
    end

    // Stage B3: squares and k2.
    logic signed [W-1:0] k2_reg, fon3, foe3, un3, ue3;
    item_t b3_reg; logic [SQ_W/2-1:0] v_b3, f_b3; logic vb3_reg;
    logic signed [W-1:0] sqn, sqe, s2c;
    assign sqn = sqq(fon_reg);
    assign sqe = sqq(foe_reg);
    assign s2c = sqq(W'({1'b0, b2_reg.s}));
    always_ff @(posedge aclk) begin
        if (!aresetn) vb3_reg <= 1'b0;
        else if (adv) vb3_reg <= vb2_reg;
        if (adv) begin
            b3_reg <= b2_reg; v_b3 <= v_b2; f_b3 <= f_b2;
            un3 <= un2; ue3 <= ue2; fon3 <= fon_reg; foe3 <= foe_reg;
            k2_reg <= s2c - (sqn + sqe);
        end
    end

    // Root of k2 scaled up; everything else rides in the tag.
    localparam int TAG3_W = ITEM_W + 2 * (SQ_W / 2) + 5 * W;
    localparam int SQ3_W  = 2 * W;
    logic [SQ3_W-1:0] rad3;
    logic [W-1:0] k_root;
    logic [TAG3_W-1:0] t3_out;
    logic signed [W-1:0] k2_pos;
    assign k2_pos = (k2_reg > TOL) ? k2_reg : '0;
    assign rad3   = SQ3_W'(k2_pos) << FB;
    wcc_isqrt #(.IN_W(SQ3_W), .TAG_W(TAG3_W)) u_sqrt_k (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .radicand(rad3),
        .tag_in({b3_reg, v_b3, f_b3, un3, ue3, fon3, foe3, k2_reg}),
        .root(k_root), .tag_out(t3_out)
    );
    logic [W-1:0] vk_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vk_reg <= '0;
        else if (adv) vk_reg <= {vk_reg[W-2:0], vb3_reg};
    end
    item_t it_c; logic [SQ_W/2-1:0] v_c, f_c;
    logic signed [W-1:0] un_k, ue_k, fon_k, foe_k, k2_k;
    assign {it_c, v_c, f_c, un_k, ue_k, fon_k, foe_k, k2_k} = t3_out;

    // Stage C1: both candidate courses.
    logic signed [W-1:0] c1n_reg, c1e_reg, c2n_reg, c2e_reg, unc, uec, fonc, foec, k2c;
    item_t c1_reg; logic [SQ_W/2-1:0] v_c1, f_c1; logic vc1_reg;
    logic signed [W-1:0] knc, kec;
    assign knc = mq(k_root, un_k);
    assign kec = mq(k_root, ue_k);
    always_ff @(posedge aclk) begin
        if (!aresetn) vc1_reg <= 1'b0;
        else if (adv) vc1_reg <= vk_reg[W-1];
        if (adv) begin
            c1_reg <= it_c; v_c1 <= v_c; f_c1 <= f_c;
            unc <= un_k; uec <= ue_k; fonc <= fon_k; foec <= foe_k; k2c <= k2_k;
            c1n_reg <= -knc - fon_k; c1e_reg <= -kec - foe_k;
            c2n_reg <= knc - fon_k;  c2e_reg <= kec - foe_k;
        end
    end

    // Stage C2: projected ground speeds of both candidates.
    logic signed [W-1:0] vp1_reg, vp2_reg;
    logic signed [W-1:0] c1n2, c1e2, c2n2, c2e2, fon2c, foe2c, k22;
    item_t c2_reg; logic [SQ_W/2-1:0] v_c2, f_c2; logic vc2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vc2_reg <= 1'b0;
        else if (adv) vc2_reg <= vc1_reg;
        if (adv) begin
            c2_reg <= c1_reg; v_c2 <= v_c1; f_c2 <= f_c1;
            c1n2 <= c1n_reg; c1e2 <= c1e_reg; c2n2 <= c2n_reg; c2e2 <= c2e_reg;
            fon2c <= fonc; foe2c <= foec; k22 <= k2c;
            vp1_reg <= mq(c1n_reg + W'(c1_reg.wn), unc) + mq(c1e_reg + W'(c1_reg.we), uec);
            vp2_reg <= mq(c2n_reg + W'(c1_reg.wn), unc) + mq(c2e_reg + W'(c1_reg.we), uec);
        end
    end

    // Stage C3: case selection and saturation.
    function automatic logic [DW-1:0] sat(input logic signed [W-1:0] x);
        logic signed [W-1:0] hi, lo;
        hi = W'((64'sd1 <<< (DW-1)) - 1);
        lo = -hi - 1;
        if (x > hi) sat = DW'(hi);
        else if (x < lo) sat = DW'(lo);
        else sat = DW'(x);
    endfunction

    function automatic logic signed [W-1:0] adif(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        adif = (a > b) ? a - b : b - a;
    endfunction

    logic signed [W-1:0] sel_n, sel_e, vv;
    logic sel_valid;
    case_t sel_case;
    always_comb begin
        vv = W'({1'b0, v_c2});
        if (v_c2 == '0) begin
            sel_n = -W'(c2_reg.wn); sel_e = -W'(c2_reg.we);
            sel_valid = adif(W'({1'b0, f_c2}), W'({1'b0, c2_reg.s})) < TOL;
            sel_case = CASE_HOVER;
        end else if (k22 <= -TOL) begin
            sel_n = W'(c2_reg.dn); sel_e = W'(c2_reg.de);
            sel_valid = 1'b0; sel_case = CASE_NO_ROOT;
        end else if (k22 <= TOL) begin
            sel_n = -fon2c; sel_e = -foe2c;
            sel_valid = 1'b1; sel_case = CASE_TANGENT;
        end else if (vp1_reg >= 0 && adif(vv, vp1_reg) < adif(vv, vp2_reg)) begin
            sel_n = c1n2; sel_e = c1e2;
            sel_valid = 1'b1; sel_case = CASE_BACKWARD;
        end else begin
            sel_n = c2n2; sel_e = c2e2;
            sel_valid = (vp2_reg >= 0); sel_case = CASE_FORWARD;
        end
    end

    typedef struct packed {
        logic [DW-1:0] cn;
        logic [DW-1:0] ce;
        logic          ok;
        logic [2:0]    kase;
    } res_t;

    res_t res_c, out_reg, skid_reg;
    logic vo_reg;
    assign res_c = '{cn: sat(sel_n), ce: sat(sel_e), ok: sel_valid, kase: sel_case};
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (adv) vo_reg <= vc2_reg;
        if (adv) out_reg <= res_c;
    end

    // Skid buffer: up to two finished beats wait for the result side.
    res_t q0_reg, q1_reg;
    logic push, pop;
    assign push = adv && vo_reg;
    assign pop  = m_valid && m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
        if (pop) begin
            q0_reg <= (cnt_reg == 2'd2) ? q1_reg : out_reg;
            if (push && cnt_reg == 2'd2) q1_reg <= out_reg;
        end else if (push) begin
            if (cnt_reg == 2'd0) q0_reg <= out_reg;
            else q1_reg <= out_reg;
        end
    end
    assign skid_reg = q0_reg;

    assign m_valid          = (cnt_reg != 2'd0);
    assign m_course_north   = skid_reg.cn;
    assign m_course_east    = skid_reg.ce;
    assign m_solution_valid = skid_reg.ok;
    assign m_solution_case  = skid_reg.kase;

    logic unused;
    assign unused = ^{dummy_tag, t2_dummy, it_a_s.vld, it_b.vld, it_c.vld, b3_reg.vld,
                      c2_reg.vld, k2_pos[W-1]};

    `WCC_ASSERT_IMPL(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= 2'd2, "skid count overflow")
    `WCC_ASSERT_IMPL(a_ready_room, aclk, aresetn, s_ready, cnt_reg != 2'd2, "ready with full skid")
    `WCC_ASSERT_NEXT(a_hold_full, aclk, aresetn, m_valid && !m_ready,
                     m_valid, "result withdrawn")
    `WCC_ASSERT_IMPL(a_case_range, aclk, aresetn, m_valid, m_solution_case <= 3'd4,
                     "case code out of range")
endmodule
`default_nettype wire
